// ----- rtl/itoa_pkg.sv -----
// Package for the integer-to-ASCII converter: microcode words, program ROM,
// datapath control/status types and character constants.
// No dependencies.
`default_nettype none

package itoa_pkg;

  // Format kinds carried in the input transaction
  localparam logic [1:0] KIND_SDEC = 2'd0;
  localparam logic [1:0] KIND_UDEC = 2'd1;
  localparam logic [1:0] KIND_HEX  = 2'd2;

  localparam logic [6:0] CHAR_MINUS = 7'h2d;
  localparam logic [6:0] CHAR_ZERO  = 7'h30;
  localparam logic [6:0] CHAR_A     = 7'h61;
  localparam logic [3:0] DEC_BASE   = 4'd10;

  // Program addresses
  localparam int PC_W = 3;
  localparam logic [PC_W-1:0] PC_WAIT = 3'd0;
  localparam logic [PC_W-1:0] PC_SIGN = 3'd1;
  localparam logic [PC_W-1:0] PC_CONV = 3'd2;
  localparam logic [PC_W-1:0] PC_SKIP = 3'd3;
  localparam logic [PC_W-1:0] PC_EMIT = 3'd4;
  localparam logic [PC_W-1:0] PC_DONE = 3'd5;

  // Jump conditions
  localparam logic [2:0] C_NONE   = 3'd0;
  localparam logic [2:0] C_ALWAYS = 3'd1;
  localparam logic [2:0] C_NO_IN  = 3'd2;
  localparam logic [2:0] C_HEX    = 3'd3;
  localparam logic [2:0] C_CNT    = 3'd4;
  localparam logic [2:0] C_LEAD0  = 3'd5;
  localparam logic [2:0] C_MORE   = 3'd6;

  typedef struct packed {
    logic            in_rdy;
    logic            dab;
    logic            sgn;
    logic            skip;
    logic            emit;
    logic [2:0]      cond;
    logic [PC_W-1:0] target;
  } uword_t;

  // Gated strobes to the datapath
  typedef struct packed {
    logic in_rdy;
    logic dab;
    logic sgn;
    logic skip;
    logic emit;
  } dp_ctl_t;

  // Flags from the datapath to the sequencer
  typedef struct packed {
    logic in_acc;
    logic neg;
    logic hex;
    logic cnt_more;
    logic lead0;
    logic more;
    logic slot_free;
  } dp_stat_t;

  function automatic uword_t ucode(input logic [PC_W-1:0] pc);
    uword_t w;
    w = '0;
    case (pc)
      PC_WAIT: begin
        w.in_rdy = 1'b1; w.cond = C_NO_IN; w.target = PC_WAIT;
      end
      PC_SIGN: begin
        w.sgn = 1'b1; w.cond = C_HEX; w.target = PC_SKIP;
      end
      PC_CONV: begin
        w.dab = 1'b1; w.cond = C_CNT; w.target = PC_CONV;
      end
      PC_SKIP: begin
        w.skip = 1'b1; w.cond = C_LEAD0; w.target = PC_SKIP;
      end
      PC_EMIT: begin
        w.emit = 1'b1; w.cond = C_MORE; w.target = PC_EMIT;
      end
      PC_DONE: begin
        w.cond = C_ALWAYS; w.target = PC_WAIT;
      end
      default: begin
        w.cond = C_ALWAYS; w.target = PC_WAIT;
      end
    endcase
    return w;
  endfunction

  function automatic logic [6:0] digit_char(input logic [3:0] d);
    logic [6:0] c;
    if (d < DEC_BASE) begin
      c = CHAR_ZERO + {3'b000, d};
    end else begin
      c = CHAR_A + {3'b000, d - DEC_BASE};
    end
    return c;
  endfunction

endpackage

`default_nettype wire

// ----- rtl/integer_to_ascii_dec_hex_top.sv -----
// Channel  Dir  tdata                               tuser  tlast
// in_      in   [VW-1:0] value, [VW+1:VW] kind      -      -
// out_     out  [6:0] character                     -      last_char
//
// Decimal: a sign step, the one-bit-per-cycle shift-add-3 loop, a leading-zero
// skip and one character per cycle while the output accepts it. Hexadecimal:
// the same steps without the shift-add-3 loop.
// Reset (rst_n low, synchronous) returns the program to its wait step and
// empties the output register. A stalled output holds the program in place.
// Top level of the integer-to-ASCII converter; uses itoa_pkg, itoa_seq, itoa_dp.
`default_nettype none

module integer_to_ascii_dec_hex_top #(
  parameter int VALUE_WIDTH = 32
) (
  input  wire                                    clk,
  input  wire                                    rst_n,
  input  wire                                    in_tvalid,
  output logic                                   in_tready,
  // value (VALUE_WIDTH bits), kind (2 bits), zero fill
  input  wire [((VALUE_WIDTH + 2 + 7) / 8) * 8 - 1:0] in_tdata,
  output logic                                   out_tvalid,
  input  wire                                    out_tready,
  // character (7 bits), zero fill
  output logic [7:0]                             out_tdata,
  output logic                                   out_tlast
);

  // Decimal digits needed for the largest VALUE_WIDTH-bit value
  localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;

  itoa_pkg::dp_ctl_t  ctl;
  itoa_pkg::dp_stat_t stat;
  logic [6:0]         ochar;

  itoa_seq u_seq (
    .clk   (clk),
    .rst_n (rst_n),
    .stat  (stat),
    .ctl   (ctl)
  );

  itoa_dp #(
    .VALUE_WIDTH (VALUE_WIDTH),
    .NDIG        (NDIG)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .ctl       (ctl),
    .stat      (stat),
    .in_valid  (in_tvalid),
    .in_value  (in_tdata[VALUE_WIDTH-1:0]),
    .in_kind   (in_tdata[VALUE_WIDTH+1:VALUE_WIDTH]),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_char  (ochar),
    .out_last  (out_tlast)
  );

  assign in_tready = ctl.in_rdy;
  assign out_tdata = {1'b0, ochar};

endmodule

`default_nettype wire

// ----- rtl/itoa_seq.sv -----
// Microcode sequencer: program counter, ROM lookup and conditional jumps.
// Depends on itoa_pkg.
`default_nettype none

module itoa_seq (
  input  wire                 clk,
  input  wire                 rst_n,
  input  wire itoa_pkg::dp_stat_t stat,
  output itoa_pkg::dp_ctl_t   ctl
);

  logic [itoa_pkg::PC_W-1:0] pc_r, pc_nxt;
  itoa_pkg::uword_t          uw;
  logic                      take;
  logic                      hold;

  assign uw = itoa_pkg::ucode(pc_r);

  // A step that writes a character waits for the output register
  assign hold = ((uw.sgn && stat.neg) || uw.emit) && !stat.slot_free;

  always_comb begin
    case (uw.cond)
      itoa_pkg::C_NONE:   take = 1'b0;
      itoa_pkg::C_ALWAYS: take = 1'b1;
      itoa_pkg::C_NO_IN:  take = !stat.in_acc;
      itoa_pkg::C_HEX:    take = stat.hex;
      itoa_pkg::C_CNT:    take = stat.cnt_more;
      itoa_pkg::C_LEAD0:  take = stat.lead0;
      itoa_pkg::C_MORE:   take = stat.more;
      default:            take = 1'b1;
    endcase
  end

  always_comb begin
    if (hold) begin
      pc_nxt = pc_r;
    end else if (take) begin
      pc_nxt = uw.target;
    end else begin
      pc_nxt = pc_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pc_r <= itoa_pkg::PC_WAIT;
    end else begin
      pc_r <= pc_nxt;
    end
  end

  assign ctl.in_rdy = uw.in_rdy;
  assign ctl.dab    = uw.dab && !hold;
  assign ctl.sgn    = uw.sgn && !hold;
  assign ctl.skip   = uw.skip && !hold;
  assign ctl.emit   = uw.emit && !hold;

endmodule

`default_nettype wire

// ----- rtl/itoa_dp.sv -----
// Datapath: magnitude and BCD shift registers (shift-add-3), digit pointer,
// output register. Driven by itoa_seq strobes. Depends on itoa_pkg.
`default_nettype none

module itoa_dp #(
  parameter int VALUE_WIDTH = 32,
  parameter int NDIG        = 10
) (
  input  wire                     clk,
  input  wire                     rst_n,
  input  wire itoa_pkg::dp_ctl_t  ctl,
  output itoa_pkg::dp_stat_t      stat,
  input  wire                     in_valid,
  input  wire [VALUE_WIDTH-1:0]   in_value,
  input  wire [1:0]               in_kind,
  output logic                    out_valid,
  input  wire                     out_ready,
  output logic [6:0]              out_char,
  output logic                    out_last
);

  localparam int BW    = NDIG * 4;
  localparam int PTR_W = $clog2(NDIG);
  localparam int CNT_W = $clog2(VALUE_WIDTH + 1);

  logic [VALUE_WIDTH-1:0] mag_r, mag_nxt;
  logic [BW-1:0]          bcd_r, bcd_nxt;
  logic [BW-1:0]          adj;
  logic [CNT_W-1:0]       cnt_r, cnt_nxt;
  logic [PTR_W-1:0]       ptr_r, ptr_nxt;
  logic                   neg_r, neg_nxt;
  logic                   hex_r, hex_nxt;
  logic                   ov_r, ov_nxt;
  logic [6:0]             oc_r, oc_nxt;
  logic                   ol_r, ol_nxt;
  logic                   in_acc;
  logic                   neg_in;
  logic                   hex_in;
  logic [3:0]             cur_dig;
  logic                   slot_free;

  assign in_acc    = in_valid && ctl.in_rdy;
  assign neg_in    = (in_kind == itoa_pkg::KIND_SDEC) && in_value[VALUE_WIDTH-1];
  assign hex_in    = (in_kind == itoa_pkg::KIND_HEX);
  assign cur_dig   = bcd_r[ptr_r*4 +: 4];
  assign slot_free = !ov_r || out_ready;

  // Add 3 to every digit of 5 or more before the shift
  always_comb begin
    for (int i = 0; i < NDIG; i++) begin
      adj[i*4 +: 4] = (bcd_r[i*4 +: 4] >= 4'd5) ? bcd_r[i*4 +: 4] + 4'd3
                                                 : bcd_r[i*4 +: 4];
    end
  end

  always_comb begin
    mag_nxt = mag_r;
    bcd_nxt = bcd_r;
    cnt_nxt = cnt_r;
    ptr_nxt = ptr_r;
    neg_nxt = neg_r;
    hex_nxt = hex_r;
    ov_nxt  = ov_r && !out_ready;
    oc_nxt  = oc_r;
    ol_nxt  = ol_r;
    if (in_acc) begin
      neg_nxt = neg_in;
      hex_nxt = hex_in;
      mag_nxt = hex_in ? '0 : (neg_in ? (~in_value + 1'b1) : in_value);
      bcd_nxt = hex_in ? BW'(in_value) : '0;
      cnt_nxt = CNT_W'(VALUE_WIDTH);
      ptr_nxt = PTR_W'(NDIG - 1);
    end
    if (ctl.dab) begin
      bcd_nxt = {adj[BW-2:0], mag_r[VALUE_WIDTH-1]};
      mag_nxt = {mag_r[VALUE_WIDTH-2:0], 1'b0};
      cnt_nxt = cnt_r - 1'b1;
    end
    if (ctl.skip && cur_dig == 4'd0 && ptr_r != '0) begin
      ptr_nxt = ptr_r - 1'b1;
    end
    if (ctl.sgn && neg_r) begin
      ov_nxt = 1'b1;
      oc_nxt = itoa_pkg::CHAR_MINUS;
      ol_nxt = 1'b0;
    end
    if (ctl.emit) begin
      ov_nxt  = 1'b1;
      oc_nxt  = itoa_pkg::digit_char(cur_dig);
      ol_nxt  = (ptr_r == '0);
      ptr_nxt = ptr_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ov_r <= 1'b0;
    end else begin
      ov_r <= ov_nxt;
    end
    mag_r <= mag_nxt;
    bcd_r <= bcd_nxt;
    cnt_r <= cnt_nxt;
    ptr_r <= ptr_nxt;
    neg_r <= neg_nxt;
    hex_r <= hex_nxt;
    oc_r  <= oc_nxt;
    ol_r  <= ol_nxt;
  end

  assign stat.in_acc    = in_acc;
  assign stat.neg       = neg_r;
  assign stat.hex       = hex_r;
  assign stat.cnt_more  = (cnt_r != CNT_W'(1));
  assign stat.lead0     = (cur_dig == 4'd0) && (ptr_r != '0);
  assign stat.more      = (ptr_r != '0);
  assign stat.slot_free = slot_free;

  assign out_valid = ov_r;
  assign out_char  = oc_r;
  assign out_last  = ol_r;

`ifndef SYNTHESIS
  // The whole magnitude has been shifted into the digit register
  a_conv_done: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.dab && cnt_r == CNT_W'(1) |=> mag_r == '0)
    else $error("magnitude not exhausted after conversion");

  // A new number starts only once the previous one has reached its last char
  a_accept_clean: assert property (@(posedge clk) disable iff (!rst_n)
    in_acc |-> !ov_r || ol_r)
    else $error("input taken while a number is still being emitted");

  // The minus sign never closes a number
  a_sign_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    ov_r && oc_r == itoa_pkg::CHAR_MINUS |-> !ol_r)
    else $error("minus sign marked last");

  // No leading zero digit is emitted ahead of the final digit
  a_no_lead0: assert property (@(posedge clk) disable iff (!rst_n)
    ctl.emit && ptr_r != '0 && $past(ctl.skip) |-> cur_dig != 4'd0)
    else $error("leading zero emitted");
`endif

endmodule

`default_nettype wire

// ----- verif/integer_to_ascii_dec_hex_top_tb.sv -----
// Testbench for integer_to_ascii_dec_hex_top: streams numbers in every format and checks
// each emitted character and its end-of-number flag against a local formatter.
// Depends on itoa_pkg and the RTL top level; self-contained otherwise.
`timescale 1ns / 100ps

module integer_to_ascii_dec_hex_top_tb;

  localparam int VW = 32;
  localparam int DW = ((VW + 2 + 7) / 8) * 8;
  localparam logic [1:0] KIND_SPARE = 2'd3;  // unused code, formats as unsigned decimal
  localparam int TEXT_W = 8 * 11;
  localparam logic [TEXT_W-1:0] NO_TEXT = '0;
  localparam int NUM_PROBES = 24;
  localparam int PHASE_ITEMS = 100;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 100;

  typedef struct packed {
    logic [6:0] code;
    logic       last;
  } glyph_t;

  // text is the expected string, left-padded with NUL bytes; NO_TEXT means predict it
  typedef struct packed {
    logic [VW-1:0]     value;
    logic [1:0]        kind;
    logic [TEXT_W-1:0] text;
  } probe_t;

  logic          clk = 1'b0;
  logic          rst_n = 1'b0;
  logic          in_tvalid = 1'b0;
  logic          in_tready;
  logic [DW-1:0] in_tdata = '0;   // value, kind, zero fill
  logic          out_tvalid;
  logic          out_tready = 1'b0;
  logic [7:0]    out_tdata;       // character, zero fill
  logic          out_tlast;

  glyph_t      pending_chars[$];
  int unsigned fault_count = 0;
  int unsigned tx_idle_pct = 0;
  int unsigned rx_stall_pct = 0;
  logic        rx_hold_go = 1'b0;
  logic        rx_hold_spent = 1'b0;
  int unsigned rx_hold_left = 0;

  int unsigned tx_mix [4] = '{0, 46, 0, 13};
  int unsigned rx_mix [4] = '{0, 0, 46, 13};

  probe_t probes [NUM_PROBES] = '{
    '{32'h0000_0000, itoa_pkg::KIND_SDEC, "0"},
    '{32'h0000_0000, itoa_pkg::KIND_UDEC, "0"},
    '{32'h0000_0000, itoa_pkg::KIND_HEX,  "0"},
    '{32'h0000_0000, KIND_SPARE,          "0"},
    '{32'hffff_ffff, itoa_pkg::KIND_SDEC, "-1"},
    '{32'hffff_ffff, itoa_pkg::KIND_UDEC, "4294967295"},
    '{32'hffff_ffff, itoa_pkg::KIND_HEX,  "ffffffff"},
    '{32'hffff_ffff, KIND_SPARE,          "4294967295"},
    '{32'h8000_0000, itoa_pkg::KIND_SDEC, "-2147483648"},
    '{32'h8000_0000, itoa_pkg::KIND_UDEC, "2147483648"},
    '{32'h8000_0000, itoa_pkg::KIND_HEX,  "80000000"},
    '{32'h8000_0000, KIND_SPARE,          "2147483648"},
    '{32'h7fff_ffff, itoa_pkg::KIND_SDEC, "2147483647"},
    '{32'h7fff_ffff, itoa_pkg::KIND_HEX,  "7fffffff"},
    '{32'h8000_0001, itoa_pkg::KIND_SDEC, "-2147483647"},
    '{32'h0000_0009, itoa_pkg::KIND_SDEC, "9"},
    '{32'h0000_000a, itoa_pkg::KIND_UDEC, "10"},
    '{32'h0000_000f, itoa_pkg::KIND_HEX,  "f"},
    '{32'h0000_0010, itoa_pkg::KIND_HEX,  "10"},
    '{32'h1234_5678, itoa_pkg::KIND_SDEC, NO_TEXT},
    '{32'hdead_beef, itoa_pkg::KIND_SDEC, NO_TEXT},
    '{32'h3b9a_c9ff, itoa_pkg::KIND_UDEC, NO_TEXT},
    '{32'h3b9a_ca00, itoa_pkg::KIND_HEX,  NO_TEXT},
    '{32'hcafe_f00d, KIND_SPARE,          NO_TEXT}
  };

  integer_to_ascii_dec_hex_top #(
    .VALUE_WIDTH(VW)
  ) DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast)
  );

  always #1 clk = ~clk;

  // Queue the characters of one number, most significant digit first.
  task automatic spell_number(input logic [VW-1:0] value, input logic [1:0] kind);
    logic [VW-1:0] mag;
    logic [VW-1:0] radix;
    logic [3:0]    digit;
    logic [6:0]    digits[$];
    mag = value;
    radix = 32'd10;
    if (kind == itoa_pkg::KIND_SDEC && value[VW-1]) begin
      pending_chars.push_back(glyph_t'{code: itoa_pkg::CHAR_MINUS, last: 1'b0});
      mag = -value;  // most negative value wraps to itself, read as unsigned
    end else if (kind == itoa_pkg::KIND_HEX) begin
      radix = 32'd16;
    end
    do begin
      digit = 4'(mag % radix);
      digits.push_front(digit < 4'd10 ? itoa_pkg::CHAR_ZERO + 7'(digit)
                                      : itoa_pkg::CHAR_A + 7'(digit - 4'd10));
      mag = mag / radix;
    end while (mag != '0);
    foreach (digits[i]) begin
      pending_chars.push_back(glyph_t'{code: digits[i], last: i == digits.size() - 1});
    end
  endtask

  task automatic spell_text(input logic [TEXT_W-1:0] text);
    glyph_t run[$];
    for (int b = TEXT_W / 8 - 1; b >= 0; b--) begin
      if (text[8*b +: 8] != 8'h00) run.push_back(glyph_t'{code: text[8*b +: 7], last: 1'b0});
    end
    run[run.size() - 1].last = 1'b1;
    foreach (run[i]) pending_chars.push_back(run[i]);
  endtask

  // Present one transaction; valid stays high afterwards unless the next call idles.
  task automatic offer(input logic [VW-1:0] value, input logic [1:0] kind,
                       input logic [TEXT_W-1:0] text);
    if (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < tx_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata <= DW'({kind, value});
    do @(posedge clk); while (in_tready !== 1'b1);
    if (text != NO_TEXT) spell_text(text);
    else spell_number(value, kind);
  endtask

  task automatic await_idle();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (pending_chars.size() != 0);
  endtask

  function automatic logic [VW-1:0] pick_value();
    logic [VW-1:0] v;
    logic [VW-1:0] p;
    v = $urandom;
    p = 32'd1;
    case ($urandom_range(6))
      0: v = v >> $urandom_range(VW - 1);     // spread digit counts
      1: v = -(v >> $urandom_range(VW - 1));  // negatives of every size
      2: v = $urandom_range(20);
      3: begin
        // decimal digit-count boundaries
        repeat ($urandom_range(9)) p = p * 32'd10;
        v = p - 32'($urandom_range(1));
      end
      4: v = (32'd1 << (4 * $urandom_range(7))) - 32'($urandom_range(1));
      5: v = 32'h8000_0000 + 32'($urandom_range(2)) - 32'd1;
      default: v = v;
    endcase
    return v;
  endfunction

  function automatic logic [1:0] pick_kind();
    return ($urandom_range(9) == 0) ? KIND_SPARE : 2'($urandom_range(2));
  endfunction

  // Receiver: one long hold-off when asked, random stalls otherwise.
  always @(posedge clk) begin
    if (rx_hold_left != 0) begin
      out_tready <= 1'b0;
      rx_hold_left <= rx_hold_left - 1;
    end else if (rx_hold_go && !rx_hold_spent) begin
      out_tready <= 1'b0;
      rx_hold_left <= HOLD_CYCLES;
      rx_hold_spent <= 1'b1;
    end else begin
      out_tready <= ($urandom_range(99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin : check_output
    glyph_t want;
    if (rst_n && out_tvalid === 1'b1 && out_tready) begin
      if (pending_chars.size() == 0) begin
        $display("%0t: unexpected character %h last %b", $time, out_tdata, out_tlast);
        fault_count++;
      end else begin
        want = pending_chars.pop_front();
        if (out_tdata !== {1'b0, want.code}) begin
          $display("%0t: character expected %h got %h", $time, {1'b0, want.code}, out_tdata);
          fault_count++;
        end
        if (out_tlast !== want.last) begin
          $display("%0t: last flag expected %b got %b", $time, want.last, out_tlast);
          fault_count++;
        end
      end
    end
  end

  initial begin
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    foreach (probes[i]) offer(probes[i].value, probes[i].kind, probes[i].text);
    for (int phase = 0; phase < 4; phase++) begin
      tx_idle_pct = tx_mix[phase];
      rx_stall_pct <= rx_mix[phase];
      // back up the output while the sender keeps pushing
      if (phase == 0) rx_hold_go <= 1'b1;
      for (int n = 0; n < PHASE_ITEMS; n++) offer(pick_value(), pick_kind(), NO_TEXT);
      await_idle();
    end
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

  initial begin
    #600000;
    $display("FAILURE");
    $finish;
  end

endmodule
